### sv/bounded_deque_with_min_max_unit_macros.svh
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Shared assertion forms for the deque with min and max tracking.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_MIN_MAX_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_MIN_MAX_UNIT_MACROS_SVH

// Checked at every clock edge outside reset.
`define BDQMM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BDQMM_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/bdqmm_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Sizes, operation codes and payload types of the deque with min and max.
// ----------------------------------------------------------------------------
`default_nettype none

package bdqmm_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
   localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
   localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
   localparam logic [1:0] KIND_POP_BACK   = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic signed [DATA_W-1:0] max_value;
      logic signed [DATA_W-1:0] min_value;
      logic [COUNT_W-1:0]       count;
      logic                     empty_res;
      logic                     error;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } scan_ctl_type;

endpackage

`default_nettype wire

### sv/bdqmm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdqmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire  [$clog2(DEPTH)-1:0]        wr_addr,
   input  wire  [WIDTH-1:0]                wr_data,
   input  wire  [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/bdqmm_scan.sv
// ----------------------------------------------------------------------------
// Deque scan unit
// Folds the stream of stored values into front, back, maximum and minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module bdqmm_scan (
   input  wire                                       clock,
   input  bdqmm_pkg::scan_ctl_type                   ctl,
   input  wire  [bdqmm_pkg::DATA_W-1:0]              data,
   output logic signed [bdqmm_pkg::DATA_W-1:0]       front_ff,
   output logic signed [bdqmm_pkg::DATA_W-1:0]       back_ff,
   output logic signed [bdqmm_pkg::DATA_W-1:0]       max_ff,
   output logic signed [bdqmm_pkg::DATA_W-1:0]       min_ff
);

   logic signed [bdqmm_pkg::DATA_W-1:0] word;
   logic signed [bdqmm_pkg::DATA_W-1:0] front_in;
   logic signed [bdqmm_pkg::DATA_W-1:0] back_in;
   logic signed [bdqmm_pkg::DATA_W-1:0] max_in;
   logic signed [bdqmm_pkg::DATA_W-1:0] min_in;

   assign word = $signed(data);

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      if (ctl.valid) begin
         if (ctl.first) begin
            front_in = word;
            max_in   = word;
            min_in   = word;
         end else begin
            if (word > max_ff) begin
               max_in = word;
            end
            if (word < min_ff) begin
               min_in = word;
            end
         end
         if (ctl.last) begin
            back_in = word;
         end
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      back_ff  <= back_in;
      max_ff   <= max_in;
      min_ff   <= min_in;
   end

endmodule

`default_nettype wire

### sv/bounded_deque_with_min_max_unit.sv
// ----------------------------------------------------------------------------
// Bounded deque with min and max
// Ring-stored double-ended queue that reports ends, extremes and count.
// ----------------------------------------------------------------------------
// A request is accepted only in idle; unless the deque is then empty, the scan
// reads every stored value, front to back, through the single read port. The
// response is registered once the output register is free, and no new request
// is taken until that response has been loaded.
// Reset clears the indexes, the count and all handshake state; the value
// memory is not cleared and needs no clearing pass.
`default_nettype none
`include "bounded_deque_with_min_max_unit_macros.svh"

module bounded_deque_with_min_max_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  bdqmm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output bdqmm_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam int IDX_W = bdqmm_pkg::IDX_W;
   localparam int CNT_W = bdqmm_pkg::CNT_W;

   function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(bdqmm_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(bdqmm_pkg::DEPTH - 1) : i - 1'b1;
   endfunction

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [IDX_W-1:0]   back_ff, back_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               error_ff, error_in;
   logic [IDX_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               data_valid_ff, data_valid_in;
   logic               last_ff, last_in;
   logic               first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bdqmm_pkg::rsp_type rsp_ff, rsp_in;

   logic                          req_fire;
   logic                          full;
   logic                          empty;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic                          op_error;
   logic                          rsp_load;
   logic [bdqmm_pkg::DATA_W-1:0]  rd_data;
   bdqmm_pkg::scan_ctl_type       scan_ctl;
   logic signed [bdqmm_pkg::DATA_W-1:0] scan_front;
   logic signed [bdqmm_pkg::DATA_W-1:0] scan_back;
   logic signed [bdqmm_pkg::DATA_W-1:0] scan_max;
   logic signed [bdqmm_pkg::DATA_W-1:0] scan_min;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(bdqmm_pkg::DEPTH));
   assign empty     = (count_ff == '0);

   // Index and count update for the accepted request.
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      op_error = 1'b0;
      case (req_data.kind)
         bdqmm_pkg::KIND_PUSH_FRONT, bdqmm_pkg::KIND_PUSH_BACK: begin
            if (full) begin
               op_error = 1'b1;
            end else if (empty) begin
               back_in  = front_ff;
               wr_en    = 1'b1;
               wr_addr  = front_ff;
               count_in = CNT_W'(1);
            end else if (req_data.kind == bdqmm_pkg::KIND_PUSH_FRONT) begin
               front_in = slot_prev(front_ff);
               wr_en    = 1'b1;
               wr_addr  = slot_prev(front_ff);
               count_in = count_ff + 1'b1;
            end else begin
               back_in  = slot_next(back_ff);
               wr_en    = 1'b1;
               wr_addr  = slot_next(back_ff);
               count_in = count_ff + 1'b1;
            end
         end
         bdqmm_pkg::KIND_POP_FRONT: begin
            if (empty) begin
               op_error = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               if (count_ff != CNT_W'(1)) begin
                  front_in = slot_next(front_ff);
               end
            end
         end
         default: begin
            if (empty) begin
               op_error = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               if (count_ff != CNT_W'(1)) begin
                  back_in = slot_prev(back_ff);
               end
            end
         end
      endcase
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      error_in      = error_ff;
      rd_addr_in    = rd_addr_ff;
      issue_in      = issue_ff;
      data_valid_in = 1'b0;
      last_in       = 1'b0;
      first_in      = first_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               error_in   = op_error;
               rd_addr_in = front_in;
               issue_in   = count_in;
               first_in   = 1'b1;
               state_in   = (count_in == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff != '0) begin
               rd_addr_in    = slot_next(rd_addr_ff);
               issue_in      = issue_ff - 1'b1;
               data_valid_in = 1'b1;
               last_in       = (issue_ff == CNT_W'(1));
            end
            if (data_valid_ff) begin
               first_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in.count     = bdqmm_pkg::COUNT_W'(count_ff);
      rsp_in.empty_res = empty;
      rsp_in.error     = error_ff;
      if (empty) begin
         rsp_in.front_value = '0;
         rsp_in.back_value  = '0;
         rsp_in.max_value   = '0;
         rsp_in.min_value   = '0;
      end else begin
         rsp_in.front_value = scan_front;
         rsp_in.back_value  = scan_back;
         rsp_in.max_value   = scan_max;
         rsp_in.min_value   = scan_min;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         front_ff      <= '0;
         back_ff       <= '0;
         count_ff      <= '0;
         error_ff      <= 1'b0;
         issue_ff      <= '0;
         data_valid_ff <= 1'b0;
         last_ff       <= 1'b0;
         first_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         error_ff      <= error_in;
         issue_ff      <= issue_in;
         data_valid_ff <= data_valid_in;
         last_ff       <= last_in;
         first_ff      <= first_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_fire) begin
            front_ff <= front_in;
            back_ff  <= back_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign scan_ctl.valid = data_valid_ff;
   assign scan_ctl.first = first_ff;
   assign scan_ctl.last  = last_ff;

   bdqmm_ram #(
      .WIDTH (bdqmm_pkg::DATA_W),
      .DEPTH (bdqmm_pkg::DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en && req_fire),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   bdqmm_scan u_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .data     (rd_data),
      .front_ff (scan_front),
      .back_ff  (scan_back),
      .max_ff   (scan_max),
      .min_ff   (scan_min)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BDQMM_ASSERT(a_count_bound, count_ff <= CNT_W'(bdqmm_pkg::DEPTH), "count above depth")
   `BDQMM_ASSERT(a_full_push_err, (req_fire && full && !req_data.kind[1]) |=> error_ff, "full push not rejected")
   `BDQMM_ASSERT(a_count_moves, (req_fire && !op_error) |=> (count_ff != $past(count_ff)), "count did not change")
   `BDQMM_ASSERT(a_data_in_scan, data_valid_ff |-> (state_ff == ST_SCAN), "read data outside scan")
   `BDQMM_ASSERT_ALWAYS(a_ready_idle, req_ready |-> !data_valid_ff, "request taken while scanning")

endmodule

`default_nettype wire
